// ===== design/lzdr_pkg.sv =====
// shared types and constants for the rotated lzss decompressor
// item structs, window request struct and the byte unscramble function
// no dependencies
package lzdr_pkg;

  localparam int WIN_DEPTH = 4096;
  localparam int WIN_AW = $clog2(WIN_DEPTH);
  localparam logic [WIN_AW-1:0] PTR_START = WIN_AW'(WIN_DEPTH - 18);
  localparam logic [WIN_AW:0] WIN_FULL = (WIN_AW + 1)'(WIN_DEPTH);
  localparam logic [4:0] LEN_BIAS = 5'd3;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       last_in;
  } code_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
  } data_item_t;

  typedef struct packed {
    logic              we;
    logic [WIN_AW-1:0] waddr;
    logic [7:0]        wdata;
    logic              re;
    logic [WIN_AW-1:0] raddr;
  } win_req_t;

  function automatic logic [7:0] unscramble(input logic [7:0] b, input logic [2:0] r);
    logic [15:0] d;
    d = {b, b} >> r;
    return d[7:0];
  endfunction

endpackage

// ===== design/lzdr_window.sv =====
// history window memory, one write and one read port, registered read
// forwards the byte written in the same cycle as a read of that entry
// depends on lzdr_pkg
module lzdr_window (
  input  logic              clk,
  input  lzdr_pkg::win_req_t req,
  output logic [7:0]        rdata
);

  logic [7:0] mem [lzdr_pkg::WIN_DEPTH];
  logic [7:0] q;
  logic       fwd;
  logic [7:0] fwd_data;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      q        <= mem[req.raddr];
      fwd      <= req.we && (req.waddr == req.raddr);
      fwd_data <= req.wdata;
    end
  end

  assign rdata = fwd ? fwd_data : q;

endmodule

// ===== design/lzss_decompress_rotated.sv =====
// rotated lzss decompressor, 4096-byte window held in one synchronous memory
// output path: a literal is registered onto the data channel in the cycle after its item is accepted;
// a match's bytes pass through the copy state, the window read register and the data register
// throughput: one output byte per cycle while data_stall is low; code items wait during a copy
// reset: synchronous, clears control state; window contents are masked by a fill count,
// so no clearing pass is needed and an item is accepted in the cycle after reset
module lzss_decompress_rotated (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 code_valid,
  output logic                 code_stall,
  input  lzdr_pkg::code_item_t code,
  output logic                 data_valid,
  input  logic                 data_stall,
  output lzdr_pkg::data_item_t data
);

  localparam int AW = lzdr_pkg::WIN_AW;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_COPY = 2'b10
  } state_t;

  state_t               state, state_next;
  logic [2:0]           position, position_next;
  logic [8:0]           flag_shift, flag_shift_next;
  logic [7:0]           match_low, match_low_next;
  logic                 match_pending, match_pending_next;
  logic [AW-1:0]        wptr, wptr_next;
  logic [AW:0]          fill, fill_next;
  logic [AW-1:0]        src, src_next;
  logic [4:0]           iss_left, iss_left_next;
  logic [4:0]           cons_left, cons_left_next;
  logic                 rd_valid, rd_valid_next;
  logic                 rd_ok, rd_ok_next;
  logic                 clear_pend, clear_pend_next;
  logic                 data_valid_next;
  lzdr_pkg::data_item_t data_next;

  lzdr_pkg::win_req_t   req;
  logic [7:0]           rdata;
  logic [7:0]           b;
  logic                 adv;
  logic                 code_fire;
  logic                 consume;
  logic                 issue;
  logic                 do_clear;
  logic [AW-1:0]        off;
  logic [4:0]           len;

  lzdr_window u_window (
    .clk   (clk),
    .req   (req),
    .rdata (rdata)
  );

  always_comb begin
    adv        = !data_valid || !data_stall;
    code_stall = !((state == ST_IDLE) && adv);
    code_fire  = code_valid && !code_stall;
    b          = lzdr_pkg::unscramble(code.in_byte, position);
    len        = {1'b0, b[3:0]} + lzdr_pkg::LEN_BIAS;

    state_next         = state;
    position_next      = position;
    flag_shift_next    = flag_shift;
    match_low_next     = match_low;
    match_pending_next = match_pending;
    wptr_next          = wptr;
    fill_next          = fill;
    src_next           = src;
    iss_left_next      = iss_left;
    cons_left_next     = cons_left;
    rd_valid_next      = rd_valid;
    rd_ok_next         = rd_ok;
    clear_pend_next    = clear_pend;
    data_valid_next    = data_valid && data_stall;
    data_next          = data;
    consume            = 1'b0;
    issue              = 1'b0;
    do_clear           = 1'b0;
    off                = '0;

    req       = '0;
    req.waddr = wptr;
    req.raddr = src;
    req.wdata = b;

    unique case (state)
      ST_IDLE: begin
        if (code_fire) begin
          position_next = position + 3'd1;
          if (match_pending) begin
            src_next           = {b[7:4], match_low};
            iss_left_next      = len;
            cons_left_next     = len;
            match_pending_next = 1'b0;
            flag_shift_next    = flag_shift >> 1;
            clear_pend_next    = code.last_in;
            state_next         = ST_COPY;
          end else if (flag_shift <= 9'd1) begin
            flag_shift_next = {1'b1, b};
          end else if (flag_shift[0]) begin
            req.we          = 1'b1;
            data_valid_next = 1'b1;
            data_next       = '{out_byte: b, run_last: 1'b1};
            flag_shift_next = flag_shift >> 1;
          end else begin
            match_low_next     = b;
            match_pending_next = 1'b1;
          end
          if (code.last_in) begin
            position_next      = '0;
            flag_shift_next    = '0;
            match_low_next     = '0;
            match_pending_next = 1'b0;
            do_clear           = !match_pending;
          end
        end
      end
      ST_COPY: begin
        consume = rd_valid && adv;
        issue   = (iss_left != 5'd0) && (!rd_valid || adv);
        if (consume) begin
          req.we          = 1'b1;
          req.wdata       = rd_ok ? rdata : 8'h00;
          data_valid_next = 1'b1;
          data_next       = '{out_byte: req.wdata, run_last: (cons_left == 5'd1)};
          cons_left_next  = cons_left - 5'd1;
          if (cons_left == 5'd1) begin
            state_next      = ST_IDLE;
            do_clear        = clear_pend;
            clear_pend_next = 1'b0;
          end
        end
        if (issue) begin
          req.re        = 1'b1;
          src_next      = src + AW'(1);
          iss_left_next = iss_left - 5'd1;
        end
        rd_valid_next = issue || (rd_valid && !consume);
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    if (req.we) begin
      wptr_next = wptr + AW'(1);
      fill_next = (fill == lzdr_pkg::WIN_FULL) ? fill : fill + (AW + 1)'(1);
    end
    if (issue) begin
      off        = src - lzdr_pkg::PTR_START;
      rd_ok_next = {1'b0, off} < fill_next;
    end
    if (do_clear) begin
      wptr_next = lzdr_pkg::PTR_START;
      fill_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      position      <= '0;
      flag_shift    <= '0;
      match_low     <= '0;
      match_pending <= 1'b0;
      wptr          <= lzdr_pkg::PTR_START;
      fill          <= '0;
      iss_left      <= '0;
      cons_left     <= '0;
      rd_valid      <= 1'b0;
      clear_pend    <= 1'b0;
      data_valid    <= 1'b0;
    end else begin
      state         <= state_next;
      position      <= position_next;
      flag_shift    <= flag_shift_next;
      match_low     <= match_low_next;
      match_pending <= match_pending_next;
      wptr          <= wptr_next;
      fill          <= fill_next;
      iss_left      <= iss_left_next;
      cons_left     <= cons_left_next;
      rd_valid      <= rd_valid_next;
      clear_pend    <= clear_pend_next;
      data_valid    <= data_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    src   <= src_next;
    rd_ok <= rd_ok_next;
    data  <= data_next;
  end

  a_read_only_in_copy: assert property (@(posedge clk) disable iff (rst)
    rd_valid |-> (state == ST_COPY))
    else $error("window read pending outside a copy");

  a_copy_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_COPY) |-> (cons_left == iss_left + {4'd0, rd_valid}))
    else $error("copy issue and consume counts out of step");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= lzdr_pkg::WIN_FULL)
    else $error("window fill count beyond depth");

  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (iss_left == 5'd0) && (cons_left == 5'd0))
    else $error("copy counters busy while idle");

endmodule

// ===== tb/lzdr_stream_checker.sv =====
// checker for the rotated lzss decompressor: watches both channels, decodes each
// accepted code item into the bytes it should produce and compares the data items
// depends on lzdr_pkg
module lzdr_stream_checker (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 code_valid,
  input  logic                 code_stall,
  input  lzdr_pkg::code_item_t code,
  input  logic                 data_valid,
  input  logic                 data_stall,
  input  lzdr_pkg::data_item_t data,
  output int                   fail_count,
  output int                   pending
);

  localparam int AW = lzdr_pkg::WIN_AW;

  lzdr_pkg::data_item_t expected_bytes[$];
  logic [7:0]           win_mem [lzdr_pkg::WIN_DEPTH];
  int unsigned          win_tag [lzdr_pkg::WIN_DEPTH];
  int unsigned          stream_tag;
  logic [AW-1:0]        wr_ptr;
  logic [2:0]           pos;
  logic [8:0]           flags;
  logic [7:0]           off_low;
  logic                 have_low;

  function automatic logic [7:0] rot_right(input logic [7:0] b, input logic [2:0] r);
    return (b >> r) | (b << (4'd8 - {1'b0, r}));
  endfunction

  task automatic restart_stream();
    stream_tag = stream_tag + 1;
    wr_ptr     = lzdr_pkg::PTR_START;
    pos        = '0;
    flags      = '0;
    off_low    = '0;
    have_low   = 1'b0;
  endtask

  task automatic store_byte(input logic [7:0] v);
    win_mem[wr_ptr] = v;
    win_tag[wr_ptr] = stream_tag;
    wr_ptr = wr_ptr + AW'(1);
  endtask

  task automatic decode_code_item(input lzdr_pkg::code_item_t c);
    logic [7:0]    b;
    logic [7:0]    v;
    logic [AW-1:0] src;
    int            n_out;
    b   = rot_right(c.in_byte, pos);
    pos = pos + 3'd1;
    if (have_low) begin
      src   = {b[7:4], off_low};
      n_out = int'(b[3:0]) + int'(lzdr_pkg::LEN_BIAS);
      for (int k = 0; k < n_out; k++) begin
        v   = (win_tag[src] == stream_tag) ? win_mem[src] : 8'h00;
        src = src + AW'(1);
        store_byte(v);
        expected_bytes.push_back('{out_byte: v, run_last: (k == n_out - 1)});
      end
      have_low = 1'b0;
      flags    = flags >> 1;
    end else if (flags <= 9'd1) begin
      flags = {1'b1, b};
    end else if (flags[0]) begin
      store_byte(b);
      expected_bytes.push_back('{out_byte: b, run_last: 1'b1});
      flags = flags >> 1;
    end else begin
      off_low  = b;
      have_low = 1'b1;
    end
    if (c.last_in) restart_stream();
  endtask

  task automatic check_data_item(input lzdr_pkg::data_item_t d);
    lzdr_pkg::data_item_t e;
    if (expected_bytes.size() == 0) begin
      fail_count = fail_count + 1;
      if (fail_count <= 10)
        $display("unexpected data item: out_byte=%h run_last=%b", d.out_byte, d.run_last);
    end else begin
      e = expected_bytes.pop_front();
      if (d.out_byte !== e.out_byte || d.run_last !== e.run_last) begin
        fail_count = fail_count + 1;
        if (fail_count <= 10)
          $display("data mismatch: out_byte exp %h got %h, run_last exp %b got %b",
                   e.out_byte, d.out_byte, e.run_last, d.run_last);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      expected_bytes.delete();
      restart_stream();
    end else begin
      if (data_valid && !data_stall) check_data_item(data);
      if (code_valid && !code_stall) decode_code_item(code);
    end
    pending <= expected_bytes.size();
  end

endmodule

// ===== tb/tb_lzss_decompress_rotated.sv =====
// testbench top for lzss_decompress_rotated: directed and random compressed streams
// with random idling on both channels; checking is done by lzdr_stream_checker
// depends on lzdr_pkg, lzss_decompress_rotated and lzdr_stream_checker
module tb_lzss_decompress_rotated;

  typedef logic [7:0] byte_q_t[$];

  localparam int LIMIT = 200000;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 code_valid = 1'b0;
  logic                 code_stall;
  lzdr_pkg::code_item_t code = '0;
  logic                 data_valid;
  logic                 data_stall = 1'b0;
  lzdr_pkg::data_item_t data;
  int                   fail_count;
  int                   pending;
  int                   send_idle = 0;
  int                   recv_idle = 0;
  int                   items_sent = 0;
  int                   cycle_count = 0;

  lzss_decompress_rotated dut (
    .clk        (clk),
    .rst        (rst),
    .code_valid (code_valid),
    .code_stall (code_stall),
    .code       (code),
    .data_valid (data_valid),
    .data_stall (data_stall),
    .data       (data)
  );

  lzdr_stream_checker chk (
    .clk        (clk),
    .rst        (rst),
    .code_valid (code_valid),
    .code_stall (code_stall),
    .code       (code),
    .data_valid (data_valid),
    .data_stall (data_stall),
    .data       (data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    data_stall <= ($urandom_range(99) < recv_idle);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("[lzss_decompress_rotated] ERROR");
      $finish;
    end
  end

  function automatic logic [7:0] rot_left(input logic [7:0] b, input logic [2:0] r);
    return (b << r) | (b >> (4'd8 - {1'b0, r}));
  endfunction

  task automatic send_code(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_idle) begin
      code_valid <= 1'b0;
      code       <= {8'($urandom), 1'($urandom)};
      @(posedge clk);
    end
    code_valid <= 1'b1;
    code       <= {b, last};
    do @(posedge clk); while (code_stall);
    items_sent = items_sent + 1;
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (pending != 0);
  endtask

  // bytes are plain stream bytes, scrambled here by their position in the stream
  task automatic send_seq(input byte_q_t seq, input int n_send);
    for (int i = 0; i < n_send; i++)
      send_code(rot_left(seq[i], 3'(i)), i == n_send - 1);
  endtask

  task automatic send_stream(input int n_groups, input bit cut);
    byte_q_t     sbytes;
    logic [7:0]  flag;
    logic [11:0] wp;
    logic [11:0] off;
    int          len;
    int          n_send;
    wp = lzdr_pkg::PTR_START;
    repeat (n_groups) begin
      flag = 8'($urandom);
      sbytes.push_back(flag);
      for (int i = 0; i < 8; i++) begin
        if (flag[i]) begin
          sbytes.push_back(8'($urandom));
          wp = wp + 12'd1;
        end else begin
          len = $urandom_range(15);
          if ($urandom_range(3) != 0) off = wp - 12'($urandom_range(1, 40));
          else off = 12'($urandom);
          sbytes.push_back(off[7:0]);
          sbytes.push_back({off[11:8], 4'(len)});
          wp = wp + 12'(len + 3);
        end
      end
    end
    n_send = cut ? $urandom_range(1, sbytes.size()) : sbytes.size();
    send_seq(sbytes, n_send);
  endtask

  task automatic send_noise(input int n);
    for (int i = 0; i < n; i++)
      send_code(8'($urandom), i == n - 1);
  endtask

  initial begin
    byte_q_t d;
    int      target;
    int      send_pct [3];
    int      recv_pct [3];
    send_pct = '{35, 49, 0};
    recv_pct = '{49, 35, 0};
    repeat (2) @(posedge clk);
    rst       <= 1'b0;
    send_idle  = send_pct[0];
    recv_idle <= recv_pct[0];

    // literals at both extremes, overlapping copy, copy of unwritten zeros, cut-off match
    d = {8'h13, 8'h00, 8'hff, 8'hef, 8'hf0, 8'h00, 8'h0f, 8'ha5, 8'hee, 8'hf2, 8'h00};
    send_seq(d, d.size());
    // flag byte as the final item
    d = {8'h55};
    send_seq(d, d.size());
    // flag reload, then a copy from an entry written only by an earlier stream
    d = {8'hff, 8'h80, 8'h01, 8'h7f, 8'hfe, 8'h00, 8'hff, 8'hc3, 8'h3c,
         8'h00, 8'h05, 8'h00};
    send_seq(d, d.size());

    for (int ph = 0; ph < 3; ph++) begin
      send_idle  = send_pct[ph];
      recv_idle <= recv_pct[ph];
      target     = items_sent + 100;
      while (items_sent < target) begin
        if ($urandom_range(4) == 0) send_noise($urandom_range(1, 12));
        else send_stream($urandom_range(1, 3), $urandom_range(2) == 0);
      end
      code_valid <= 1'b0;
      wait_drained();
    end

    repeat (40) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("[lzss_decompress_rotated] OK");
    end else begin
      $display("[lzss_decompress_rotated] ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/lzdr_pkg.sv
design/lzdr_window.sv
design/lzss_decompress_rotated.sv
tb/lzdr_stream_checker.sv
tb/tb_lzss_decompress_rotated.sv
